// File: hw/rtl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types, codes and elaboration helpers for the positional array list.
// ----------------------------------------------------------------------------
package pal_pkg;

	localparam int CAPACITY_DEF    = 1024;
	localparam int VALUE_WIDTH_DEF = 16;
	localparam int OPCODE_W        = 3;
	localparam int POS_W           = 11;
	localparam int FIELD_W         = 16;
	localparam int COUNT_W         = 11;
	localparam int STATUS_W        = 2;
	localparam int TREE_FANIN      = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INS_FRONT = 3'd0,
		OP_INS_END   = 3'd1,
		OP_INS_POS   = 3'd2,
		OP_REM_FRONT = 3'd3,
		OP_REM_END   = 3'd4,
		OP_REM_POS   = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [POS_W-1:0]    position;
		logic [FIELD_W-1:0]  entry_value;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FIELD_W-1:0]  removed_value;
		logic [COUNT_W-1:0]  entry_count;
	} out_item_t;

	// Shift command broadcast to every slot cell
	typedef struct packed {
		logic ins;
		logic rem;
	} cell_cmd_t;

	// Number of registered levels in the read-out tree
	function automatic int tree_levels(input int n);
		int m;
		int lv;
		m  = n;
		lv = 1;
		while (m > TREE_FANIN) begin
			m  = (m + TREE_FANIN - 1) / TREE_FANIN;
			lv = lv + 1;
		end
		return lv;
	endfunction

endpackage

// File: hw/rtl/pal_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_cell
// One slot of the list: holds an entry and shifts with its neighbours.
// ----------------------------------------------------------------------------
module pal_cell #(
	parameter int VW    = 16,
	parameter int IDX_W = 10,
	parameter int INDEX = 0
) (
	input  logic                 clk,
	input  pal_pkg::cell_cmd_t   cmd,
	input  logic [IDX_W-1:0]     slot,
	input  logic [VW-1:0]        ins_val,
	input  logic [VW-1:0]        below,
	input  logic [VW-1:0]        above,
	output logic [VW-1:0]        value,
	output logic [VW-1:0]        tap
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

	logic [VW-1:0] value_q;
	logic          at_slot;
	logic          above_slot;

	assign at_slot    = (slot == MY_IDX);
	assign above_slot = (MY_IDX > slot);

	// Insert shifts up from the slot, remove shifts down onto it
	always_ff @(posedge clk) begin
		if (cmd.ins && at_slot) begin
			value_q <= ins_val;
		end else if (cmd.ins && above_slot) begin
			value_q <= below;
		end else if (cmd.rem && (at_slot || above_slot)) begin
			value_q <= above;
		end
	end

	assign value = value_q;
	// Offer the entry to the read-out tree only when it is being removed
	assign tap   = (cmd.rem && at_slot) ? value_q : '0;

endmodule

// File: hw/rtl/pal_or_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_or_tree
// Registered OR tree that collects the one non-zero cell tap.
// ----------------------------------------------------------------------------
module pal_or_tree #(
	parameter int N = 1024,
	parameter int W = 16
) (
	input  logic                clk,
	input  logic [N-1:0][W-1:0] leaves,
	output logic [W-1:0]        root
);

	localparam int G = pal_pkg::TREE_FANIN;
	localparam int M = (N + G - 1) / G;

	// Groups of leaves, bit-major so each output bit is one reduction
	logic [M-1:0][W-1:0][G-1:0] part;
	logic [M-1:0][W-1:0]        grp;

	genvar g, b, k;
	generate
		for (g = 0; g < M; g++) begin : g_grp
			for (b = 0; b < W; b++) begin : g_bit
				for (k = 0; k < G; k++) begin : g_leaf
					if (g * G + k < N) begin : g_used
						assign part[g][b][k] = leaves[g * G + k][b];
					end else begin : g_pad
						assign part[g][b][k] = 1'b0;
					end
				end
				assign grp[g][b] = |part[g][b];
			end
		end

		if (M == 1) begin : g_last
			logic [W-1:0] root_q;
			// Register the final reduction
			always_ff @(posedge clk) begin
				root_q <= grp[0];
			end
			assign root = root_q;
		end else begin : g_more
			logic [M-1:0][W-1:0] grp_q;
			// Register this level, then reduce further
			always_ff @(posedge clk) begin
				grp_q <= grp;
			end
			pal_or_tree #(
				.N(M),
				.W(W)
			) u_next (
				.clk   (clk),
				.leaves(grp_q),
				.root  (root)
			);
		end
	endgenerate

endmodule

// File: hw/rtl/positional_array_list_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_core
// Ordered list of up to CAPACITY entries with positional insert and remove.
// ----------------------------------------------------------------------------
// Usage:
//   A command arrives on the in channel (in_valid / in_ready, payload in_data)
//   and yields exactly one result on the out channel (out_valid / out_ready,
//   payload out_data) carrying status, removed value and new entry count.
//   Entries sit in a chain of slot cells; an insert or remove moves every
//   affected entry by one slot in the cycle the command is transferred.
//   The removed entry is collected by a registered OR tree of
//   LAT = tree_levels(CAPACITY) levels (two for 1024 slots, fan-in 32).
//   The result passes through the tree levels and then the output register.
//   One command is in flight at a time; a new command is taken only once
//   the previous one has left the read-out tree, so the depth of the tree
//   sets how often commands are taken.
//   A stalled receiver holds the result in the output register and in_ready
//   stays low until it is transferred.
//   Reset clears the entry count and the control state; slot contents are
//   not cleared and are only ever read below the count.
// ----------------------------------------------------------------------------
module positional_array_list_core #(
	parameter int CAPACITY    = pal_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = pal_pkg::VALUE_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  pal_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output pal_pkg::out_item_t  out_data
);

	localparam int VW    = VALUE_WIDTH;
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > pal_pkg::POS_W) ? CNT_W : pal_pkg::POS_W;
	localparam int FW    = pal_pkg::FIELD_W;
	localparam int CW    = pal_pkg::COUNT_W;
	localparam int LAT   = pal_pkg::tree_levels(CAPACITY);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	logic                  accept;
	logic                  out_take;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nx;
	logic [CMP_W-1:0]      pos_c;
	logic [CMP_W-1:0]      cnt_c;
	logic                  full;
	logic                  empty;
	pal_pkg::status_t      status_d;
	pal_pkg::cell_cmd_t    cmd_d;
	pal_pkg::cell_cmd_t    cmd;
	logic [IDX_W-1:0]      slot_d;
	logic [VW+FW-1:0]      ins_wide;
	logic [VW-1:0]         ins_val;
	logic [LAT-1:0]        stage_q;
	logic                  busy;
	pal_pkg::status_t      status_q;
	logic [CNT_W-1:0]      res_count_q;
	logic [VW-1:0]         root;
	logic [FW+VW-1:0]      rem_wide;
	logic [CW+CNT_W-1:0]   cnt_wide;
	logic                  out_valid_q;
	pal_pkg::out_item_t    out_data_q;

	logic [CAPACITY-1:0][VW-1:0] cell_val;
	logic [CAPACITY-1:0][VW-1:0] cell_tap;

	assign accept   = in_valid && in_ready;
	assign out_take = out_valid_q && out_ready;
	assign busy     = |stage_q;
	assign in_ready = !busy && (!out_valid_q || out_ready);

	// Bring position and count to a common width for the range checks
	assign pos_c = CMP_W'(in_data.position);
	assign cnt_c = CMP_W'(count_q);
	assign full  = (count_q == CAP_C);
	assign empty = (count_q == '0);

	// Value cut or widened to the stored width
	assign ins_wide = {{VW{1'b0}}, in_data.entry_value};
	assign ins_val  = ins_wide[VW-1:0];

	// Decode the command into a shift and a status
	always_comb begin
		status_d = pal_pkg::ST_OK;
		cmd_d    = '0;
		slot_d   = '0;
		unique case (pal_pkg::op_t'(in_data.opcode))
			pal_pkg::OP_INS_FRONT: begin
				if (full) status_d = pal_pkg::ST_FULL;
				else cmd_d.ins = 1'b1;
			end
			pal_pkg::OP_INS_END: begin
				slot_d = IDX_W'(count_q);
				if (full) status_d = pal_pkg::ST_FULL;
				else cmd_d.ins = 1'b1;
			end
			pal_pkg::OP_INS_POS: begin
				slot_d = IDX_W'(in_data.position);
				if (full) status_d = pal_pkg::ST_FULL;
				else if (pos_c > cnt_c) status_d = pal_pkg::ST_BADPOS;
				else cmd_d.ins = 1'b1;
			end
			pal_pkg::OP_REM_FRONT: begin
				if (empty) status_d = pal_pkg::ST_EMPTY;
				else cmd_d.rem = 1'b1;
			end
			pal_pkg::OP_REM_END: begin
				slot_d = IDX_W'(count_q - 1'b1);
				if (empty) status_d = pal_pkg::ST_EMPTY;
				else cmd_d.rem = 1'b1;
			end
			pal_pkg::OP_REM_POS: begin
				slot_d = IDX_W'(in_data.position);
				if (empty) status_d = pal_pkg::ST_EMPTY;
				else if (pos_c >= cnt_c) status_d = pal_pkg::ST_BADPOS;
				else cmd_d.rem = 1'b1;
			end
			default: begin
				status_d = pal_pkg::ST_OK;
			end
		endcase
	end

	// Only a transferred command moves the cells
	assign cmd.ins = accept && cmd_d.ins;
	assign cmd.rem = accept && cmd_d.rem;

	always_comb begin
		count_nx = count_q;
		if (cmd.ins) count_nx = count_q + 1'b1;
		else if (cmd.rem) count_nx = count_q - 1'b1;
	end

	// Chain of slot cells
	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic [VW-1:0] below;
			logic [VW-1:0] above;
			if (i == 0) begin : g_first
				assign below = ins_val;
			end else begin : g_lo
				assign below = cell_val[i-1];
			end
			if (i == CAPACITY - 1) begin : g_top
				assign above = cell_val[i];
			end else begin : g_hi
				assign above = cell_val[i+1];
			end
			pal_cell #(
				.VW   (VW),
				.IDX_W(IDX_W),
				.INDEX(i)
			) u_cell (
				.clk    (clk),
				.cmd    (cmd),
				.slot   (slot_d),
				.ins_val(ins_val),
				.below  (below),
				.above  (above),
				.value  (cell_val[i]),
				.tap    (cell_tap[i])
			);
		end
	endgenerate

	// Collect the removed entry
	pal_or_tree #(
		.N(CAPACITY),
		.W(VW)
	) u_tree (
		.clk   (clk),
		.leaves(cell_tap),
		.root  (root)
	);

	// Count and tree-latency tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			stage_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			stage_q <= (stage_q << 1) | LAT'(accept);
			if (stage_q[LAT-1]) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the status and count of the command in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status_d;
			res_count_q <= count_nx;
		end
	end

	assign rem_wide = {{FW{1'b0}}, root};
	assign cnt_wide = {{CW{1'b0}}, res_count_q};

	// Load the output register when the tree delivers
	always_ff @(posedge clk) begin
		if (stage_q[LAT-1]) begin
			out_data_q.status        <= status_q;
			out_data_q.removed_value <= rem_wide[FW-1:0];
			out_data_q.entry_count   <= cnt_wide[CW-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(count_q))
		else $error("entry count moved without a transfer");

	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(stage_q) <= 1)
		else $error("more than one command in the read-out tree");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !busy && !(out_valid_q && !out_ready))
		else $error("command taken while a result is pending");

	a_removed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_data_q.removed_value != '0)
		|-> out_data_q.status == pal_pkg::ST_OK)
		else $error("removed value reported with a failing status");

endmodule

// File: tb/positional_array_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_checker
// Watches both channels of the list core, keeps its own copy of the list,
// works out the result of every transferred command and compares each
// transferred result field by field with the oldest one still awaited.
// ----------------------------------------------------------------------------
module positional_array_list_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  pal_pkg::in_item_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  pal_pkg::out_item_t out_data,
	output int                 fail_count,
	output int                 pending,
	output int                 list_len
);

	localparam int CAPACITY = pal_pkg::CAPACITY_DEF;
	localparam int COUNT_W  = pal_pkg::COUNT_W;

	logic [pal_pkg::FIELD_W-1:0] list_slots[$];
	pal_pkg::out_item_t          awaited_results[$];

	initial begin
		fail_count = 0;
		pending    = 0;
		list_len   = 0;
	end

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what, input int want, input int got);
		fail_count++;
		$display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
	endtask

	// Apply one command to the shadow list and return the result it gives
	function automatic pal_pkg::out_item_t apply_command(input pal_pkg::in_item_t cmd);
		pal_pkg::out_item_t res;
		int                 idx;
		int                 held;
		res        = '0;
		res.status = pal_pkg::ST_OK;
		held       = list_slots.size();
		case (cmd.opcode)
			pal_pkg::OP_INS_FRONT, pal_pkg::OP_INS_END, pal_pkg::OP_INS_POS: begin
				if (cmd.opcode == pal_pkg::OP_INS_FRONT)
					idx = 0;
				else if (cmd.opcode == pal_pkg::OP_INS_END)
					idx = held;
				else
					idx = int'(cmd.position);
				// full wins over a bad position
				if (held >= CAPACITY)
					res.status = pal_pkg::ST_FULL;
				else if (idx > held)
					res.status = pal_pkg::ST_BADPOS;
				else
					list_slots.insert(idx, cmd.entry_value);
			end
			pal_pkg::OP_REM_FRONT, pal_pkg::OP_REM_END, pal_pkg::OP_REM_POS: begin
				if (cmd.opcode == pal_pkg::OP_REM_FRONT)
					idx = 0;
				else if (cmd.opcode == pal_pkg::OP_REM_END)
					idx = held - 1;
				else
					idx = int'(cmd.position);
				// empty wins over a bad position
				if (held == 0) begin
					res.status = pal_pkg::ST_EMPTY;
				end else if (idx >= held) begin
					res.status = pal_pkg::ST_BADPOS;
				end else begin
					res.removed_value = list_slots[idx];
					list_slots.delete(idx);
				end
			end
			default: ;
		endcase
		res.entry_count = COUNT_W'(list_slots.size());
		return res;
	endfunction

	// Check results first, then predict the command transferred at this edge
	always @(posedge clk or negedge arst_n) begin
		pal_pkg::out_item_t want;
		if (!arst_n) begin
			list_slots.delete();
			awaited_results.delete();
			pending  = 0;
			list_len = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with no command waiting, status",
						-1, int'(out_data.status));
				end else begin
					want = awaited_results.pop_front();
					if (out_data.status !== want.status)
						report_mismatch("status", int'(want.status),
							int'(out_data.status));
					if (out_data.removed_value !== want.removed_value)
						report_mismatch("removed_value", int'(want.removed_value),
							int'(out_data.removed_value));
					if (out_data.entry_count !== want.entry_count)
						report_mismatch("entry_count", int'(want.entry_count),
							int'(out_data.entry_count));
				end
			end
			if (in_valid && in_ready)
				awaited_results.push_back(apply_command(in_data));
			pending  = awaited_results.size();
			list_len = list_slots.size();
		end
	end

endmodule

// File: tb/positional_array_list_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_core_test
// Drives commands into the list core under changing flow control: a short
// directed run over empty, bad-position and spare-opcode cases, then random
// traffic that fills the list to capacity and then removes part of it. The checker
// beside the core does the prediction; this module gives the verdict.
// ----------------------------------------------------------------------------
module positional_array_list_core_test;

	localparam int CAPACITY = pal_pkg::CAPACITY_DEF;
	localparam int OPCODE_W = pal_pkg::OPCODE_W;
	localparam int POS_W    = pal_pkg::POS_W;
	localparam int FIELD_W  = pal_pkg::FIELD_W;
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {
		FLOW_FREE,
		FLOW_SRC_IDLE,
		FLOW_SINK_STALL,
		FLOW_BOTH
	} flow_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	pal_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	pal_pkg::out_item_t out_data;

	int    fail_count;
	int    pending;
	int    list_len;
	int    issued;
	flow_t flow_mode;

	positional_array_list_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	positional_array_list_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.list_len   (list_len)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up long after the slowest correct run would have ended
	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Stall the result channel according to the current flow mode
	always @(negedge clk) begin
		case (flow_mode)
			FLOW_SINK_STALL: out_ready <= ($urandom_range(99) >= 64);
			FLOW_BOTH:       out_ready <= ($urandom_range(99) >= 10);
			default:         out_ready <= 1'b1;
		endcase
	end

	function automatic int idle_cycles();
		int pct;
		int gap;
		pct = (flow_mode == FLOW_SRC_IDLE) ? 64 : (flow_mode == FLOW_BOTH) ? 10 : 0;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < pct)
			gap++;
		return gap;
	endfunction

	function automatic pal_pkg::in_item_t make_item(input logic [OPCODE_W-1:0] op,
		input int pos, input int val);
		pal_pkg::in_item_t item;
		item.opcode      = op;
		item.position    = POS_W'(pos);
		item.entry_value = FIELD_W'(val);
		return item;
	endfunction

	// Random command; ins_pct sets the percentage of inserts, positions mostly legal
	function automatic pal_pkg::in_item_t random_command(input int ins_pct);
		pal_pkg::in_item_t item;
		int                pick;
		int                roll;
		logic              is_ins;
		item.entry_value = FIELD_W'($urandom_range(16'hFFFF));
		pick             = $urandom_range(2);
		is_ins           = ($urandom_range(99) < ins_pct);
		if ($urandom_range(99) < 3)
			item.opcode = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
		else if (is_ins)
			item.opcode = (pick == 0) ? pal_pkg::OP_INS_FRONT :
				(pick == 1) ? pal_pkg::OP_INS_END : pal_pkg::OP_INS_POS;
		else
			item.opcode = (pick == 0) ? pal_pkg::OP_REM_FRONT :
				(pick == 1) ? pal_pkg::OP_REM_END : pal_pkg::OP_REM_POS;
		roll = $urandom_range(99);
		if (roll < 75) begin
			if (is_ins)
				item.position = POS_W'($urandom_range(list_len));
			else
				item.position = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
		end else if (roll < 88) begin
			item.position = POS_W'(list_len);
		end else begin
			item.position = POS_W'($urandom_range(2047));
		end
		return item;
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer
	task automatic transfer_cmd(input pal_pkg::in_item_t item);
		int gap;
		flow_mode = flow_t'((issued / 100) % 4);
		gap       = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		issued++;
		@(negedge clk);
	endtask

	task automatic random_run(input int count, input int ins_pct);
		repeat (count)
			transfer_cmd(random_command(ins_pct));
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		issued    = 0;
		flow_mode = FLOW_FREE;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty list, bad positions, middle shifts and spare opcodes
		transfer_cmd(make_item(pal_pkg::OP_REM_FRONT, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_END, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 2047, 16'hFFFF));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 1, 16'h1234));
		transfer_cmd(make_item(pal_pkg::OP_INS_FRONT, 2047, 16'hFFFF));
		transfer_cmd(make_item(pal_pkg::OP_INS_END, 2047, 16'h0000));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 2, 16'h8001));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 0, 16'h7FFE));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 1, 16'hA5A5));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 1024, 16'h5A5A));
		transfer_cmd(make_item(pal_pkg::OP_INS_POS, 2047, 16'h5A5A));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 5, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 1024, 0));
		transfer_cmd(make_item(OP_SPARE_LO, 3, 16'hBEEF));
		transfer_cmd(make_item(OP_SPARE_HI, 2047, 16'hFFFF));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 2, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_END, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_FRONT, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_POS, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_END, 0, 0));
		transfer_cmd(make_item(pal_pkg::OP_REM_END, 0, 0));

		// Mixed traffic at low fill, then fill to capacity and push against it
		random_run(120, 55);
		while (list_len < CAPACITY)
			transfer_cmd(random_command(96));
		random_run(25, 85);
		// Draw the fill back down with remove-heavy mixed traffic
		random_run(150, 25);

		in_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: positional_array_list_core.f
hw/rtl/pal_pkg.sv
hw/rtl/pal_cell.sv
hw/rtl/pal_or_tree.sv
hw/rtl/positional_array_list_core.sv
tb/positional_array_list_checker.sv
tb/positional_array_list_core_test.sv
